// ----- sv/ptmr_pkg.sv -----
// Package for the prescaled down-counter timer.
// Request and response types, opcodes, register indexes and control bits.
// No dependencies.
package ptmr_pkg;

  localparam int DATA_WIDTH = 24;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    REG_LOAD    = 2'd0,
    REG_COUNT   = 2'd1,
    REG_CONTROL = 2'd2,
    REG_CLEAR   = 2'd3
  } reg_index_t;

  localparam int CTRL_ENABLE_BIT   = 7;
  localparam int CTRL_PERIODIC_BIT = 6;
  localparam int CTRL_PRESCALE_LSB = 2;

  localparam logic [1:0] PRESCALE_DIV1  = 2'd0;
  localparam logic [1:0] PRESCALE_DIV16 = 2'd1;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [1:0]            reg_index;
    logic [DATA_WIDTH-1:0] write_value;
  } request_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] read_value;
    logic                  irq_pending;
  } response_t;

  // last prescaler value before a count step
  function automatic logic [7:0] prescale_last(input logic [1:0] code);
    logic [7:0] last;
    case (code)
      PRESCALE_DIV1:  last = 8'd0;
      PRESCALE_DIV16: last = 8'd15;
      default:        last = 8'd255;
    endcase
    return last;
  endfunction

endpackage

// ----- sv/ptmr_core.sv -----
// Timer state and the single-pass update for one request.
// Depends on ptmr_pkg.
module ptmr_core import ptmr_pkg::*; #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  request_t  req,
  output response_t rsp
);

  logic [COUNT_WIDTH-1:0] reload_value, reload_value_next;
  logic [COUNT_WIDTH-1:0] count_value, count_value_next;
  logic                   enable_bit, enable_bit_next;
  logic                   periodic_bit, periodic_bit_next;
  logic [1:0]             prescale_code, prescale_code_next;
  logic [7:0]             prescale_count, prescale_count_next;
  logic                   interrupt_flag, interrupt_flag_next;

  logic [COUNT_WIDTH+DATA_WIDTH-1:0] load_wide;
  logic [COUNT_WIDTH-1:0]            load_val;
  logic [COUNT_WIDTH-1:0]            rd_reg;
  logic [COUNT_WIDTH+DATA_WIDTH-1:0] rd_wide;
  logic [DATA_WIDTH-1:0]             rd_value;
  logic                              wrap;

  assign load_wide = {{COUNT_WIDTH{1'b0}}, req.write_value};
  assign load_val  = load_wide[COUNT_WIDTH-1:0];
  assign wrap      = prescale_count >= prescale_last(prescale_code);

  always_comb begin
    reload_value_next   = reload_value;
    count_value_next    = count_value;
    enable_bit_next     = enable_bit;
    periodic_bit_next   = periodic_bit;
    prescale_code_next  = prescale_code;
    prescale_count_next = prescale_count;
    interrupt_flag_next = interrupt_flag;
    rd_reg              = '0;
    case (req.opcode)
      OP_TICK: begin
        if (enable_bit) begin
          if (wrap) begin
            prescale_count_next = 8'd0;
            if (count_value <= COUNT_WIDTH'(1)) begin
              interrupt_flag_next = 1'b1;
              if (periodic_bit) begin
                count_value_next = reload_value;
              end else begin
                count_value_next = '0;
                enable_bit_next  = 1'b0;
              end
            end else begin
              count_value_next = count_value - COUNT_WIDTH'(1);
            end
          end else begin
            prescale_count_next = prescale_count + 8'd1;
          end
        end
      end
      OP_READ: begin
        case (req.reg_index)
          REG_LOAD:  rd_reg = reload_value;
          REG_COUNT: rd_reg = count_value;
          REG_CONTROL: begin
            rd_reg[CTRL_ENABLE_BIT]   = enable_bit;
            rd_reg[CTRL_PERIODIC_BIT] = periodic_bit;
            rd_reg[CTRL_PRESCALE_LSB +: 2] = prescale_code;
          end
          default: rd_reg = '0;
        endcase
      end
      OP_WRITE: begin
        case (req.reg_index)
          REG_LOAD: begin
            reload_value_next   = load_val;
            count_value_next    = load_val;
            prescale_count_next = 8'd0;
          end
          REG_CONTROL: begin
            enable_bit_next     = req.write_value[CTRL_ENABLE_BIT];
            periodic_bit_next   = req.write_value[CTRL_PERIODIC_BIT];
            prescale_code_next  = req.write_value[CTRL_PRESCALE_LSB +: 2];
            prescale_count_next = 8'd0;
          end
          REG_CLEAR: interrupt_flag_next = 1'b0;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign rd_wide  = {{DATA_WIDTH{1'b0}}, rd_reg};
  assign rd_value = rd_wide[DATA_WIDTH-1:0];

  assign rsp.read_value  = rd_value;
  assign rsp.irq_pending = interrupt_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      reload_value   <= '0;
      count_value    <= '0;
      enable_bit     <= 1'b0;
      periodic_bit   <= 1'b0;
      prescale_code  <= 2'd0;
      prescale_count <= 8'd0;
      interrupt_flag <= 1'b0;
    end else if (fire) begin
      reload_value   <= reload_value_next;
      count_value    <= count_value_next;
      enable_bit     <= enable_bit_next;
      periodic_bit   <= periodic_bit_next;
      prescale_code  <= prescale_code_next;
      prescale_count <= prescale_count_next;
      interrupt_flag <= interrupt_flag_next;
    end
  end

  // one-shot expiry stops the timer at zero with the interrupt up
  a_oneshot_stop: assert property (@(posedge clk) disable iff (rst)
    fire && req.opcode == OP_TICK && enable_bit && !periodic_bit && wrap &&
    count_value <= COUNT_WIDTH'(1)
    |=> !enable_bit && count_value == '0 && interrupt_flag)
    else $error("one-shot expiry did not stop the timer");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    fire && req.opcode == OP_WRITE && req.reg_index == REG_CLEAR |=> !interrupt_flag)
    else $error("interrupt clear write ignored");

  a_disabled_hold: assert property (@(posedge clk) disable iff (rst)
    fire && req.opcode == OP_TICK && !enable_bit
    |=> $stable(count_value) && $stable(prescale_count))
    else $error("disabled timer moved on a tick");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(count_value) && $stable(interrupt_flag))
    else $error("timer state changed without a request");

endmodule

// ----- sv/prescaled_down_counter_timer.sv -----
// Top level of the prescaled down-counter timer: request register,
// timer core and response register. Depends on ptmr_pkg and ptmr_core.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------
//   request  | in_valid / in_stall | opcode, reg_index, write_value
//   response | out_valid/out_stall | read_value, irq_pending
//
// One request per cycle while in_stall is low; a taken request passes
// through the request register, then the response register.
// The timer state updates as a request moves from the request register
// into the response register, so requests take effect strictly in order.
// rst is synchronous and clears the timer state and both valid flags.
// A stalled response holds; the request register still takes one more
// request, and in_stall rises only when both registers are full.
module prescaled_down_counter_timer import ptmr_pkg::*; #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            opcode,
  input  logic [1:0]            reg_index,
  input  logic [DATA_WIDTH-1:0] write_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_WIDTH-1:0] read_value,
  output logic                  irq_pending
);

  logic      req_valid;
  request_t  req;
  response_t rsp;
  logic      advance;
  logic      fire;

  assign advance  = !out_valid || !out_stall;
  assign fire     = req_valid && advance;
  assign in_stall = req_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      req.opcode      <= opcode;
      req.reg_index   <= reg_index;
      req.write_value <= write_value;
    end
  end

  ptmr_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .req  (req),
    .rsp  (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      read_value  <= rsp.read_value;
      irq_pending <= rsp.irq_pending;
    end
  end

endmodule

// ----- bench/tb_prescaled_down_counter_timer.sv -----
`timescale 1ns / 100ps
// Testbench for prescaled_down_counter_timer: directed and random ticks, register
// reads and writes, checked in order against a cycle-free shadow of the timer.
// Depends on ptmr_pkg and the timer RTL.
module tb_prescaled_down_counter_timer;
  import ptmr_pkg::*;

  localparam int CW = 24;
  localparam int RANDOM_ITEMS = 1520;
  localparam int HOLD_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [1:0] PRESCALE_DIV256 = 2'd2;
  localparam logic [1:0] PRESCALE_ALT256 = 2'd3;

  // Shadow of the timer registers plus the queue of responses still owed.
  class timer_shadow;
    logic [CW-1:0] reload_q;
    logic [CW-1:0] count_q;
    bit enable_q;
    bit periodic_q;
    bit irq_q;
    logic [1:0] div_code;
    logic [7:0] div_count;
    response_t owed_responses[$];
    int unsigned fail_count;

    function new();
      reload_q = '0;
      count_q = '0;
      enable_q = 1'b0;
      periodic_q = 1'b0;
      irq_q = 1'b0;
      div_code = PRESCALE_DIV1;
      div_count = '0;
      fail_count = 0;
    endfunction

    function void note_request(logic [1:0] op, logic [1:0] idx, logic [DATA_WIDTH-1:0] val);
      response_t r;
      logic [7:0] last;
      r.read_value = '0;
      case (op)
        OP_TICK: begin
          if (enable_q) begin
            case (div_code)
              PRESCALE_DIV1: last = 8'd0;
              PRESCALE_DIV16: last = 8'd15;
              default: last = 8'd255;
            endcase
            if (div_count >= last) begin
              div_count = '0;
              if (count_q <= 1) begin
                irq_q = 1'b1;
                if (periodic_q) begin
                  count_q = reload_q;
                end else begin
                  count_q = '0;
                  enable_q = 1'b0;
                end
              end else begin
                count_q = count_q - 1'b1;
              end
            end else begin
              div_count = div_count + 1'b1;
            end
          end
        end
        OP_READ: begin
          case (idx)
            REG_LOAD: r.read_value = reload_q;
            REG_COUNT: r.read_value = count_q;
            REG_CONTROL: begin
              r.read_value[CTRL_ENABLE_BIT] = enable_q;
              r.read_value[CTRL_PERIODIC_BIT] = periodic_q;
              r.read_value[CTRL_PRESCALE_LSB +: 2] = div_code;
            end
            default: ;
          endcase
        end
        OP_WRITE: begin
          case (idx)
            REG_LOAD: begin
              reload_q = val[CW-1:0];
              count_q = val[CW-1:0];
              div_count = '0;
            end
            REG_CONTROL: begin
              enable_q = val[CTRL_ENABLE_BIT];
              periodic_q = val[CTRL_PERIODIC_BIT];
              div_code = val[CTRL_PRESCALE_LSB +: 2];
              div_count = '0;
            end
            REG_CLEAR: irq_q = 1'b0;
            default: ;
          endcase
        end
        default: ;
      endcase
      r.irq_pending = irq_q;
      owed_responses.push_back(r);
    endfunction

    function void check_response(logic [DATA_WIDTH-1:0] rd, logic irq);
      response_t e;
      if (owed_responses.size() == 0) begin
        $error("unexpected response: read_value %h irq_pending %b", rd, irq);
        fail_count++;
        return;
      end
      e = owed_responses.pop_front();
      if (rd !== e.read_value) begin
        $error("read_value: expected %h, actual %h", e.read_value, rd);
        fail_count++;
      end
      if (irq !== e.irq_pending) begin
        $error("irq_pending: expected %b, actual %b", e.irq_pending, irq);
        fail_count++;
      end
    endfunction

    function int unsigned outstanding();
      return owed_responses.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [1:0] opcode;
  logic [1:0] reg_index;
  logic [DATA_WIDTH-1:0] write_value;
  logic out_valid;
  logic out_stall;
  logic [DATA_WIDTH-1:0] read_value;
  logic irq_pending;

  timer_shadow tracker;
  bit hold_off_req = 1'b0;
  int unsigned cycles = 0;

  prescaled_down_counter_timer #(.COUNT_WIDTH(CW)) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .reg_index(reg_index),
    .write_value(write_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .read_value(read_value),
    .irq_pending(irq_pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_response(read_value, irq_pending);
  end

  // response-side stall pattern; a hold-off request forces a long stall
  initial begin : response_stall_gen
    int unsigned seg;
    int unsigned mode;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        seg = $urandom_range(10, 60);
        mode = $urandom_range(0, 3);
        for (int i = 0; i < seg && !hold_off_req; i++) begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 99) < 30);
            2: out_stall <= ((i % 5) < 2);
            default: out_stall <= ($urandom_range(0, 99) < 70);
          endcase
          @(negedge clk);
        end
      end
    end
  end

  function automatic logic [DATA_WIDTH-1:0] control_word(bit en, bit per, logic [1:0] code);
    logic [DATA_WIDTH-1:0] w;
    w = '0;
    w[CTRL_ENABLE_BIT] = en;
    w[CTRL_PERIODIC_BIT] = per;
    w[CTRL_PRESCALE_LSB +: 2] = code;
    return w;
  endfunction

  task automatic send_request(logic [1:0] op, logic [1:0] idx, logic [DATA_WIDTH-1:0] val);
    @(negedge clk);
    in_valid <= 1'b1;
    opcode <= op;
    reg_index <= idx;
    write_value <= val;
    do @(posedge clk); while (in_stall);
    tracker.note_request(op, idx, val);
  endtask

  task automatic pause_requests(int unsigned n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
  endtask

  task automatic send_random_request();
    int unsigned pick;
    logic [DATA_WIDTH-1:0] v;
    logic [1:0] idx;
    pick = $urandom_range(0, 99);
    v = DATA_WIDTH'($urandom);
    idx = 2'($urandom);
    if (pick < 55) begin
      send_request(OP_TICK, idx, v);
    end else if (pick < 70) begin
      send_request(OP_READ, idx, v);
    end else if (pick < 78) begin
      if ($urandom_range(0, 9) < 7)
        v = DATA_WIDTH'($urandom_range(0, 24));
      send_request(OP_WRITE, REG_LOAD, v);
    end else if (pick < 84) begin
      v[CTRL_ENABLE_BIT] = ($urandom_range(0, 9) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 60)
        v[CTRL_PRESCALE_LSB +: 2] = PRESCALE_DIV1;
      else if (pick < 85)
        v[CTRL_PRESCALE_LSB +: 2] = PRESCALE_DIV16;
      else if (pick < 93)
        v[CTRL_PRESCALE_LSB +: 2] = PRESCALE_DIV256;
      else
        v[CTRL_PRESCALE_LSB +: 2] = PRESCALE_ALT256;
      send_request(OP_WRITE, REG_CONTROL, v);
    end else if (pick < 92) begin
      send_request(OP_WRITE, REG_CLEAR, v);
    end else if (pick < 97) begin
      send_request(OP_WRITE, REG_COUNT, v);
    end else begin
      send_request(OP_NONE, idx, v);
    end
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    bit held;
    bit drained;
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = OP_TICK;
    reg_index = REG_LOAD;
    write_value = '0;
    tracker = new();
    sent = 0;
    held = 1'b0;
    drained = 1'b0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // reset values, extremes, ignored count write
    send_request(OP_READ, REG_LOAD, '0);
    send_request(OP_READ, REG_CONTROL, '0);
    send_request(OP_WRITE, REG_LOAD, '1);
    send_request(OP_READ, REG_LOAD, '0);
    send_request(OP_WRITE, REG_COUNT, 24'h123456);
    send_request(OP_READ, REG_COUNT, '0);
    // periodic expiry at divide by 1
    send_request(OP_WRITE, REG_LOAD, 24'd3);
    send_request(OP_WRITE, REG_CONTROL, control_word(1'b1, 1'b1, PRESCALE_DIV1));
    repeat (4) send_request(OP_TICK, REG_CLEAR, '1);
    send_request(OP_READ, REG_COUNT, '0);
    // expiry while already pending, then clear
    repeat (3) send_request(OP_TICK, REG_LOAD, '0);
    send_request(OP_WRITE, REG_CLEAR, '0);
    send_request(OP_READ, REG_CLEAR, '1);
    // prescale code three with stray bits set, one-shot
    send_request(OP_WRITE, REG_CONTROL, ~control_word(1'b0, 1'b1, PRESCALE_DIV1));
    send_request(OP_READ, REG_CONTROL, '0);
    send_request(OP_NONE, REG_CONTROL, 24'hA5A5A5);
    // one-shot expiry clears enable; ticks while disabled do nothing
    send_request(OP_WRITE, REG_LOAD, 24'd1);
    send_request(OP_WRITE, REG_CONTROL, control_word(1'b1, 1'b0, PRESCALE_DIV1));
    repeat (2) send_request(OP_TICK, REG_COUNT, '0);
    send_request(OP_READ, REG_CONTROL, '0);
    // zero reload in periodic mode
    send_request(OP_WRITE, REG_LOAD, '0);
    send_request(OP_WRITE, REG_CONTROL, control_word(1'b1, 1'b1, PRESCALE_DIV1));
    send_request(OP_WRITE, REG_CLEAR, '0);
    send_request(OP_TICK, REG_LOAD, '0);

    while (sent < RANDOM_ITEMS) begin
      if (!held && sent >= 500) begin
        held = 1'b1;
        hold_off_req = 1'b1;
        repeat (32) send_random_request();
        sent += 32;
      end
      burst = $urandom_range(1, 24);
      repeat (burst) send_random_request();
      sent += burst;
      if (!drained && sent >= 1000) begin
        drained = 1'b1;
        wait_drained();
      end
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0)
        pause_requests(gap);
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (tracker.fail_count == 0 && tracker.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
